/* src/hzs_pkg.sv */
// ----------------------------------------------------------------------------
// HDLC zero-insert serializer package
// Shared item types, command codes and constants for the serializer blocks.
// ----------------------------------------------------------------------------
package hzs_pkg;

  // Input item as seen on the item channel.
  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       tx_enable;
  } item_t;

  // Result item as seen on the result channel.
  typedef struct packed {
    logic serial_out;
    logic buffer_empty;
  } result_t;

  // Command codes produced by the front end.
  localparam logic [1:0] OP_WRITE = 2'd0;  // load the holding byte
  localparam logic [1:0] OP_TICK  = 2'd1;  // enabled bit clock tick
  localparam logic [1:0] OP_HOLD  = 2'd2;  // tick with enable low, no change

  // Function field codes of an input item.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  // Serializer constants.
  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [2:0] RUN_LIMIT = 3'd5;

  // Back end status seen by the top level.
  typedef struct packed {
    logic [3:0] bits_left;
    logic [2:0] ones_run;
    logic       holding_empty;
  } status_t;

endpackage

/* src/hzs_front.sv */
// ----------------------------------------------------------------------------
// HDLC zero-insert serializer front end
// Classifies input items into commands and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module hzs_front
  import hzs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  cmd_valid,
  input  logic  cmd_ready,
  output cmd_t  cmd
);

  // Queue storage; two entries let both sides stall independently.
  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  // Classify the incoming item.
  always_comb begin
    cmd_in.data = item.data;
    if (item.func == FUNC_WRITE) begin
      cmd_in.op = OP_WRITE;
    end else if (item.tx_enable) begin
      cmd_in.op = OP_TICK;
    end else begin
      cmd_in.op = OP_HOLD;
    end
  end

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign cmd_valid  = (count != 2'd0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = entries[rd_ptr];

  // Queue payload write.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/hzs_back.sv */
// ----------------------------------------------------------------------------
// HDLC zero-insert serializer back end
// Executes commands on the holding and shift registers and registers results.
// ----------------------------------------------------------------------------
module hzs_back
  import hzs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result,
  output status_t status
);

  logic [7:0] holding_byte;
  logic       holding_empty;
  logic [7:0] shift_byte;
  logic [3:0] bits_left;
  logic [2:0] ones_run;
  logic       line_level;

  logic [7:0] holding_byte_next;
  logic       holding_empty_next;
  logic [7:0] shift_byte_next;
  logic [3:0] bits_left_next;
  logic [2:0] ones_run_next;
  logic       line_level_next;
  logic       exec;

  // A command executes when the result register is free or being drained.
  assign cmd_ready = !result_valid || result_ready;
  assign exec      = cmd_valid && cmd_ready;

  // Next state for one command.
  always_comb begin
    holding_byte_next  = holding_byte;
    holding_empty_next = holding_empty;
    shift_byte_next    = shift_byte;
    bits_left_next     = bits_left;
    ones_run_next      = ones_run;
    line_level_next    = line_level;
    case (cmd.op)
      OP_WRITE: begin
        holding_byte_next  = cmd.data;
        holding_empty_next = 1'b0;
      end
      OP_TICK: begin
        // An empty shift register first takes the held byte.
        if (bits_left == 4'd0 && !holding_empty) begin
          shift_byte_next    = holding_byte;
          bits_left_next     = BYTE_BITS;
          holding_byte_next  = 8'd0;
          holding_empty_next = 1'b1;
        end
        if (bits_left_next == 4'd0) begin
          // Idle mark, not counted toward the ones run.
          line_level_next = 1'b1;
        end else if (ones_run >= RUN_LIMIT) begin
          // Stuffed zero; the shift register does not advance.
          ones_run_next   = 3'd0;
          line_level_next = 1'b0;
        end else begin
          line_level_next = shift_byte_next[0];
          ones_run_next   = shift_byte_next[0] ? ones_run + 3'd1 : 3'd0;
          bits_left_next  = bits_left_next - 4'd1;
          if (bits_left_next == 4'd0) begin
            shift_byte_next = 8'd0;
          end else begin
            shift_byte_next = {1'b0, shift_byte_next[7:1]};
          end
        end
      end
      OP_HOLD: begin
        // Tick with the enable low leaves everything as it is.
      end
      default: begin
      end
    endcase
  end

  // Serializer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      holding_byte  <= 8'd0;
      holding_empty <= 1'b1;
      shift_byte    <= 8'd0;
      bits_left     <= 4'd0;
      ones_run      <= 3'd0;
      line_level    <= 1'b1;
    end else if (exec) begin
      holding_byte  <= holding_byte_next;
      holding_empty <= holding_empty_next;
      shift_byte    <= shift_byte_next;
      bits_left     <= bits_left_next;
      ones_run      <= ones_run_next;
      line_level    <= line_level_next;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (exec) begin
      result.serial_out   <= line_level_next;
      result.buffer_empty <= holding_empty_next;
    end
  end

  assign status.bits_left     = bits_left;
  assign status.ones_run      = ones_run;
  assign status.holding_empty = holding_empty;

endmodule

/* src/hdlc_zero_insert_serializer.sv */
// ----------------------------------------------------------------------------
// HDLC zero-insert serializer
// Double-buffered HDLC transmit serializer with zero-bit insertion.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  item      in         item_valid / item_ready      item_t   (func, data, tx_enable)
//  result    out        result_valid / result_ready  result_t (serial_out, buffer_empty)
//
// One item per clock cycle sustained while the result channel does not stall.
// A taken item enters the queue as a command; the back end registers the result
// when it executes that command, which a stalled result channel can hold back.
// The back end sets the rate, executing one command per cycle unless results stall.
// Reset is synchronous and needs no clearing pass; the line starts at mark.
// A stalled result channel fills the two-entry queue and then drops item_ready.
// ----------------------------------------------------------------------------
module hdlc_zero_insert_serializer
  import hzs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  status_t status;

  // Front end: classification and command queue.
  hzs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Back end: serializer state and result register.
  hzs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .status       (status)
  );

`ifndef NO_ASSERTIONS
  // Shift counters stay within a byte and the stuffing limit.
  assert property (@(posedge clk) disable iff (rst)
    (status.bits_left <= BYTE_BITS) && (status.ones_run <= RUN_LIMIT))
    else $error("serializer counters out of range");

  // A command never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> (!result_valid || result_ready))
    else $error("command executed over a pending result");

  // An empty queue always takes a new item.
  assert property (@(posedge clk) disable iff (rst)
    !cmd_valid |-> item_ready)
    else $error("empty queue refused an item");

  // An executed write leaves the holding buffer full.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.op == OP_WRITE) |=> !status.holding_empty)
    else $error("write did not fill the holding buffer");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDLC zero-insert serializer testbench
// Feeds write and bit-tick transfers through the item channel and checks each
// line level and buffer-empty flag against a cycle-free model of the serializer.
// ----------------------------------------------------------------------------
module tb;
  import hzs_pkg::*;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // Items waiting to be driven and line states waiting to come back.
  item_t   tx_items[$];
  result_t expected_line[$];

  // Model state of the serializer.
  logic [7:0] held_byte;
  logic       held_free;
  logic [7:0] shifter;
  logic [3:0] bits_to_go;
  logic [2:0] run_of_ones;
  logic       line_q;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  logic item_took;

  hdlc_zero_insert_serializer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one transfer to the model and returns the line state after it.
  function automatic result_t step_serializer(item_t it);
    result_t r;
    if (it.func == FUNC_WRITE) begin
      held_byte = it.data;
      held_free = 1'b0;
    end else if (it.tx_enable) begin
      // An empty shifter takes the held byte before the bit goes out.
      if (bits_to_go == 4'd0 && !held_free) begin
        shifter    = held_byte;
        bits_to_go = BYTE_BITS;
        held_byte  = 8'h00;
        held_free  = 1'b1;
      end
      if (bits_to_go == 4'd0) begin
        line_q = 1'b1;
      end else if (run_of_ones >= RUN_LIMIT) begin
        // Five ones in a row: send a stuffed zero and hold the shifter.
        run_of_ones = 3'd0;
        line_q      = 1'b0;
      end else begin
        line_q      = shifter[0];
        run_of_ones = shifter[0] ? run_of_ones + 3'd1 : 3'd0;
        shifter     = shifter >> 1;
        bits_to_go  = bits_to_go - 4'd1;
      end
    end
    r.serial_out   = line_q;
    r.buffer_empty = held_free;
    return r;
  endfunction

  task automatic queue_item(logic f, logic [7:0] d, logic en);
    item_t it;
    it.func      = f;
    it.data      = d;
    it.tx_enable = en;
    tx_items.push_back(it);
  endtask

  // Bytes skewed toward long runs of ones so that stuffing happens often.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(3))
      0:       b = 8'($urandom);
      1:       b = 8'($urandom | $urandom);
      2:       b = 8'hFF;
      default: b = 8'hFF << $urandom_range(7);
    endcase
    return b;
  endfunction

  // Random traffic: mostly enabled ticks, with the write rate varied in bursts
  // so that the holding buffer is sometimes overwritten and sometimes starved.
  task automatic queue_random(int count);
    int write_pct;
    logic f;
    write_pct = 12;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       write_pct = 4;
          1:       write_pct = 12;
          default: write_pct = 30;
        endcase
      end
      f = ($urandom_range(99) < write_pct) ? FUNC_WRITE : FUNC_TICK;
      queue_item(f, (f == FUNC_WRITE) ? pick_byte() : 8'($urandom),
                 $urandom_range(9) != 0);
    end
  endtask

  // Returns once every queued item is sent and every result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (tx_items.size() != 0 || item_valid || expected_line.size() != 0);
  endtask

  // Item driver: holds a transfer until it is taken, then may idle.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_took) begin
      if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item       <= tx_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checks each result transfer against the oldest prediction and records
  // predictions for accepted items.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      item_took <= 1'b0;
    end else begin
      item_took <= item_valid && item_ready;
      if (result_valid && result_ready) begin
        if (expected_line.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: unexpected result serial_out=%b buffer_empty=%b",
                     $realtime, result.serial_out, result.buffer_empty);
          end
        end else begin
          want = expected_line.pop_front();
          if (result.serial_out !== want.serial_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: serial_out expected %b, got %b",
                       $realtime, want.serial_out, result.serial_out);
            end
          end
          if (result.buffer_empty !== want.buffer_empty) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: buffer_empty expected %b, got %b",
                       $realtime, want.buffer_empty, result.buffer_empty);
            end
          end
        end
      end
      if (item_valid && item_ready) begin
        expected_line.push_back(step_serializer(item));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    result_ready  = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 54;
    mismatches    = 0;
    held_byte     = 8'h00;
    held_free     = 1'b1;
    shifter       = 8'h00;
    bits_to_go    = 4'd0;
    run_of_ones   = 3'd0;
    line_q        = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Idle mark tick, then a tick with the enable low.
    queue_item(FUNC_TICK, 8'hA5, 1'b1);
    queue_item(FUNC_TICK, 8'h5A, 1'b0);
    // A write with the enable low, then an overwrite of the full buffer.
    queue_item(FUNC_WRITE, 8'h00, 1'b0);
    queue_item(FUNC_WRITE, 8'hF8, 1'b1);
    // This byte ends on five ones, leaving a stuffed zero pending.
    for (int i = 0; i < 8; i++) queue_item(FUNC_TICK, 8'h00, 1'b1);
    // Idle mark bits do not add to the run.
    queue_item(FUNC_TICK, 8'hFF, 1'b1);
    queue_item(FUNC_WRITE, 8'hFF, 1'b0);
    queue_item(FUNC_TICK, 8'hFF, 1'b0);
    // The pending zero goes out before the first bit of the new byte.
    for (int i = 0; i < 4; i++) queue_item(FUNC_TICK, 8'h00, 1'b1);
    queue_item(FUNC_WRITE, 8'h80, 1'b1);
    for (int i = 0; i < 5; i++) queue_item(FUNC_TICK, 8'hFF, 1'b1);
    queue_random(550);
    wait_drained();

    // The sender has paused with nothing outstanding; swap the idle rates.
    send_idle_pct = 54;
    recv_idle_pct = 13;
    queue_random(570);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(570);
    wait_drained();

    // Watch for stray results after the last expected one.
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_line.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* hdlc_zero_insert_serializer.f */
src/hzs_pkg.sv
src/hzs_front.sv
src/hzs_back.sv
src/hdlc_zero_insert_serializer.sv
bench/tb.sv
